// ----- hw/rtl/stt_pkg.sv -----
// shared types, constants and arithmetic helpers of the shape triangle tessellator
`default_nettype none
package stt_pkg;

   localparam int COORD_W  = 24;
   localparam int HALF_W   = 23;
   localparam int SIN_W    = 18;
   localparam int IDX_W    = 13;
   localparam int CNT_W    = 15;
   localparam int PHASE_W  = 16;
   localparam int RECIP_W  = 32;
   localparam int COLOR_W  = 32;
   localparam int TRI_W    = 12;
   localparam int SIZE_W   = 22;
   localparam int WIDTH_W  = 21;
   localparam int SEG_W    = 11;
   localparam int CSR_IW   = 3;
   localparam int CSR_DW   = 32;
   localparam int STEPS    = 16;
   localparam int LANES    = 4;
   localparam int PROD_W   = HALF_W + SIN_W;
   localparam int RND_W    = PROD_W - 15;

   localparam logic [CSR_IW-1:0] REG_SHAPE_KIND    = 3'd0;
   localparam logic [CSR_IW-1:0] REG_SIZE_X        = 3'd1;
   localparam logic [CSR_IW-1:0] REG_SIZE_Y        = 3'd2;
   localparam logic [CSR_IW-1:0] REG_OUTLINE_WIDTH = 3'd3;
   localparam logic [CSR_IW-1:0] REG_SEGMENT_COUNT = 3'd4;
   localparam logic [CSR_IW-1:0] REG_FILL_COLOR    = 3'd5;
   localparam logic [CSR_IW-1:0] REG_OUTLINE_COLOR = 3'd6;

   localparam logic [1:0] ROLE_FILL  = 2'd0;
   localparam logic [1:0] ROLE_OUT_A = 2'd1;
   localparam logic [1:0] ROLE_OUT_B = 2'd2;

   localparam logic KIND_RECT    = 1'b0;
   localparam logic KIND_ELLIPSE = 1'b1;

   localparam int RECT_FILL  = 2;
   localparam int RECT_TOTAL = 10;

   localparam int COORD_MAX = 8388607;
   localparam int COORD_MIN = -8388608;
   localparam int CORDIC_X0 = 19899;
   localparam int SIN_ONE   = 32768;
   localparam int QUARTER   = 16384;
   localparam int HALF_TURN = 32768;

   localparam logic [SIN_W-1:0] ATAN [0:STEPS-1] = '{
      18'd8192, 18'd4836, 18'd2555, 18'd1297, 18'd651, 18'd326, 18'd163, 18'd81,
      18'd41, 18'd20, 18'd10, 18'd5, 18'd3, 18'd1, 18'd1, 18'd0
   };

   // bit 0 negate x, bit 1 negate y, bit 2 outer ring
   localparam logic [2:0] RECT_TRIS [0:RECT_TOTAL-1][0:2] = '{
      '{3'd3, 3'd2, 3'd0}, '{3'd3, 3'd0, 3'd1},
      '{3'd1, 3'd0, 3'd4}, '{3'd1, 3'd4, 3'd5},
      '{3'd7, 3'd6, 3'd2}, '{3'd7, 3'd2, 3'd3},
      '{3'd0, 3'd2, 3'd6}, '{3'd0, 3'd6, 3'd4},
      '{3'd3, 3'd1, 3'd5}, '{3'd3, 3'd5, 3'd7}
   };

   typedef struct packed {
      logic               valid_res;
      logic               kind;
      logic [1:0]         role;
      logic [2:0]         code0;
      logic [2:0]         code1;
      logic [2:0]         code2;
      logic [COLOR_W-1:0] color;
      logic [IDX_W-1:0]   m0;
      logic [IDX_W-1:0]   m1;
   } item_type;

   typedef struct packed {
      logic signed [HALF_W-1:0] ix;
      logic signed [HALF_W-1:0] iy;
      logic signed [HALF_W-1:0] ox;
      logic signed [HALF_W-1:0] oy;
      logic [IDX_W-1:0]         n;
      logic [RECIP_W-1:0]       recip;
   } geom_type;

   function automatic logic signed [COORD_W-1:0] mul_round(
      input logic signed [HALF_W-1:0] h,
      input logic signed [SIN_W-1:0]  s
   );
      logic signed [PROD_W-1:0] p;
      logic signed [RND_W-1:0]  r;
      p = h * s;
      p = p + PROD_W'(QUARTER);
      r = p[PROD_W-1:15];
      if (r > RND_W'(COORD_MAX)) begin
         mul_round = COORD_W'(COORD_MAX);
      end else if (r < RND_W'(COORD_MIN)) begin
         mul_round = COORD_W'(COORD_MIN);
      end else begin
         mul_round = r[COORD_W-1:0];
      end
   endfunction

   function automatic logic signed [COORD_W-1:0] rect_coord(
      input logic signed [HALF_W-1:0] h,
      input logic                     neg
   );
      logic signed [COORD_W-1:0] v;
      v = {h[HALF_W-1], h};
      rect_coord = neg ? -v : v;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/shape_triangle_tessellator.sv -----
// shape triangle tessellator top level: registers, classifier, queue and vertex pipeline
// throughput: one triangle per cycle, set by the fully pipelined 16-step cordic lanes,
// while the result channel is not stalled and the reciprocal unit is not busy
// after a segment count write the reciprocal unit recomputes, input stalls meanwhile
// reset is synchronous; after reset the reciprocal for the default count is computed first
`default_nettype none
module shape_triangle_tessellator
   import stt_pkg::*;
#(
   parameter int MAX_SEGMENTS    = 1024,
   parameter int SINE_TABLE_BITS = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [TRI_W-1:0]   req_triangle_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [COORD_W-1:0]      rsp_x0,
   output logic [COORD_W-1:0]      rsp_y0,
   output logic [COORD_W-1:0]      rsp_x1,
   output logic [COORD_W-1:0]      rsp_y1,
   output logic [COORD_W-1:0]      rsp_x2,
   output logic [COORD_W-1:0]      rsp_y2,
   output logic [COLOR_W-1:0]      rsp_vertex_color,
   output logic                    rsp_valid_res,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CSR_IW-1:0]  csr_index,
   input  wire logic [CSR_DW-1:0]  csr_data
);
   logic                      kind_ff;
   logic [SIZE_W-1:0]         size_x_ff, size_y_ff;
   logic signed [WIDTH_W-1:0] width_ff;
   logic [SEG_W-1:0]          seg_ff;
   logic [COLOR_W-1:0]        fill_ff, outline_ff;

   logic             csr_fire, div_start, div_busy;
   logic [IDX_W-1:0] n_clamp, seg_ext;
   logic [RECIP_W-1:0] recip;
   geom_type         geom;
   item_type         front_item, head_item;
   logic             q_push, q_pop, q_full, q_empty;
   logic [$bits(item_type)-1:0] head_bits;

   logic [HALF_W-1:0]        hx, hy;
   logic signed [HALF_W-1:0] wneg, wabs;

   assign csr_ready = !div_busy;
   assign csr_fire  = csr_valid && csr_ready;
   assign div_start = csr_fire && (csr_index == REG_SEGMENT_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= KIND_RECT;
         size_x_ff  <= SIZE_W'(2560);
         size_y_ff  <= SIZE_W'(2560);
         width_ff   <= WIDTH_W'(256);
         seg_ff     <= SEG_W'(32);
         fill_ff    <= 32'hFFFF_FFFF;
         outline_ff <= 32'h0000_00FF;
      end else if (csr_fire) begin
         case (csr_index)
            REG_SHAPE_KIND:    kind_ff    <= csr_data[0];
            REG_SIZE_X:        size_x_ff  <= csr_data[SIZE_W-1:0];
            REG_SIZE_Y:        size_y_ff  <= csr_data[SIZE_W-1:0];
            REG_OUTLINE_WIDTH: width_ff   <= csr_data[WIDTH_W-1:0];
            REG_SEGMENT_COUNT: seg_ff     <= csr_data[SEG_W-1:0];
            REG_FILL_COLOR:    fill_ff    <= csr_data[COLOR_W-1:0];
            REG_OUTLINE_COLOR: outline_ff <= csr_data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      seg_ext = IDX_W'(seg_ff);
      if (seg_ext < IDX_W'(3)) begin
         n_clamp = IDX_W'(3);
      end else if (seg_ext > IDX_W'(MAX_SEGMENTS)) begin
         n_clamp = IDX_W'(MAX_SEGMENTS);
      end else begin
         n_clamp = seg_ext;
      end
      hx   = (HALF_W'(size_x_ff) + 1'b1) >> 1;
      hy   = (HALF_W'(size_y_ff) + 1'b1) >> 1;
      wneg = width_ff[WIDTH_W-1] ? HALF_W'(width_ff) : '0;
      wabs = width_ff[WIDTH_W-1] ? -HALF_W'(width_ff) : HALF_W'(width_ff);
      geom.ix    = $signed(hx) + wneg;
      geom.iy    = $signed(hy) + wneg;
      geom.ox    = geom.ix + wabs;
      geom.oy    = geom.iy + wabs;
      geom.n     = n_clamp;
      geom.recip = recip;
   end

   stt_recip u_recip (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .n     (n_clamp),
      .busy  (div_busy),
      .recip (recip)
   );

   stt_front u_front (
      .triangle_index (req_triangle_index),
      .kind           (kind_ff),
      .n              (n_clamp),
      .outline_on     (width_ff != '0),
      .fill_color     (fill_ff),
      .line_color     (outline_ff),
      .item           (front_item)
   );

   assign req_stall = q_full || div_busy;
   assign q_push    = req_valid && !req_stall;

   stt_queue #(
      .WIDTH ($bits(item_type)),
      .DEPTH (4)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (front_item),
      .pop   (q_pop),
      .rdata (head_bits),
      .full  (q_full),
      .empty (q_empty)
   );

   assign head_item = item_type'(head_bits);

   stt_back #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .in_avail         (!q_empty),
      .in_item          (head_item),
      .in_pop           (q_pop),
      .geom             (geom),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_x0           (rsp_x0),
      .rsp_y0           (rsp_y0),
      .rsp_x1           (rsp_x1),
      .rsp_y1           (rsp_y1),
      .rsp_x2           (rsp_x2),
      .rsp_y2           (rsp_y2),
      .rsp_vertex_color (rsp_vertex_color),
      .rsp_valid_res    (rsp_valid_res)
   );

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> req_stall)
      else $error("input taken while reciprocal is busy");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("queue written while full");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_vertex_color == '0 && rsp_x0 == '0))
      else $error("missing triangle carries nonzero payload");
endmodule
`default_nettype wire

// ----- hw/rtl/stt_queue.sv -----
// small fifo between the classifier and the vertex pipeline
`default_nettype none
module stt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  full,
   output logic                  empty
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

   assign rdata = mem_ff[rd_ff];
   assign full  = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);
endmodule
`default_nettype wire

// ----- hw/rtl/stt_front.sv -----
// triangle classifier: range check, role, ring indexes and rectangle corners
`default_nettype none
module stt_front
   import stt_pkg::*;
(
   input  wire logic [TRI_W-1:0]   triangle_index,
   input  wire logic               kind,
   input  wire logic [IDX_W-1:0]   n,
   input  wire logic               outline_on,
   input  wire logic [COLOR_W-1:0] fill_color,
   input  wire logic [COLOR_W-1:0] line_color,
   output item_type                item
);
   logic [CNT_W-1:0] t_ext, total;
   logic [IDX_W-1:0] t13, d, a;
   logic             a_wrap;

   always_comb begin
      t_ext = CNT_W'(triangle_index);
      t13   = IDX_W'(triangle_index);
      d     = t13 - n;
      item  = '0;
      a     = '0;
      if (kind == KIND_RECT) begin
         total = outline_on ? CNT_W'(RECT_TOTAL) : CNT_W'(RECT_FILL);
         item.kind = KIND_RECT;
         if (t_ext < total) begin
            item.valid_res = 1'b1;
            item.code0 = RECT_TRIS[triangle_index[3:0]][0];
            item.code1 = RECT_TRIS[triangle_index[3:0]][1];
            item.code2 = RECT_TRIS[triangle_index[3:0]][2];
            item.color = (t_ext < CNT_W'(RECT_FILL)) ? fill_color : line_color;
         end
      end else begin
         total = outline_on ? (CNT_W'({n, 1'b0}) + CNT_W'(n)) : CNT_W'(n);
         item.kind = KIND_ELLIPSE;
         if (t_ext < total) begin
            item.valid_res = 1'b1;
            if (t13 < n) begin
               item.role  = ROLE_FILL;
               item.color = fill_color;
               a = t13;
            end else begin
               item.role  = d[0] ? ROLE_OUT_B : ROLE_OUT_A;
               item.color = line_color;
               a = d >> 1;
            end
         end
      end
      a_wrap  = (a + 1'b1 == n);
      item.m0 = a;
      item.m1 = a_wrap ? '0 : a + 1'b1;
   end
endmodule
`default_nettype wire

// ----- hw/rtl/stt_recip.sv -----
// serial reciprocal of the segment count, one quotient bit a cycle
`default_nettype none
module stt_recip
   import stt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [IDX_W-1:0] n,
   output logic                  busy,
   output logic [RECIP_W-1:0]    recip
);
   localparam int STEPS_DIV = RECIP_W + 1;
   localparam int CW        = $clog2(STEPS_DIV);

   logic             busy_ff, busy_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [RECIP_W-1:0] quo_ff, quo_in;
   logic [IDX_W:0]   trial;
   logic             qbit;

   always_comb begin
      trial   = {rem_ff, cnt_ff == '0};
      qbit    = (trial >= {1'b0, n});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = qbit ? IDX_W'(trial - {1'b0, n}) : IDX_W'(trial);
         quo_in = {quo_ff[RECIP_W-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(STEPS_DIV - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rem_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   assign busy  = busy_ff;
   assign recip = quo_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/stt_back.sv -----
// vertex pipeline: phase, cordic sine and cosine, scaling and output register
`default_nettype none
module stt_back
   import stt_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_avail,
   input  wire item_type         in_item,
   output logic                  in_pop,
   input  wire geom_type         geom,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [COORD_W-1:0]    rsp_x0,
   output logic [COORD_W-1:0]    rsp_y0,
   output logic [COORD_W-1:0]    rsp_x1,
   output logic [COORD_W-1:0]    rsp_y1,
   output logic [COORD_W-1:0]    rsp_x2,
   output logic [COORD_W-1:0]    rsp_y2,
   output logic [COLOR_W-1:0]    rsp_vertex_color,
   output logic                  rsp_valid_res
);
   localparam int SH     = PHASE_W - SINE_TABLE_BITS;
   localparam int NST    = 22;
   localparam int MUL_W  = IDX_W + RECIP_W;
   localparam int NUM_W  = IDX_W + PHASE_W;

   localparam logic [1:0] SP_NONE = 2'd0;
   localparam logic [1:0] SP_ZERO = 2'd1;
   localparam logic [1:0] SP_POS  = 2'd2;
   localparam logic [1:0] SP_NEG  = 2'd3;

   logic     en;
   logic     vld_ff [0:NST-1];
   item_type meta_ff [0:NST-1];

   logic [MUL_W-1:0]   prod_ff [0:1];
   logic [PHASE_W-1:0] q0_ff   [0:1];
   logic [NUM_W-1:0]   qn_ff   [0:1];
   logic [PHASE_W-1:0] ph_ff   [0:1];

   logic signed [SIN_W-1:0] cx_ff [0:STEPS][0:LANES-1];
   logic signed [SIN_W-1:0] cy_ff [0:STEPS][0:LANES-1];
   logic signed [SIN_W-1:0] cz_ff [0:STEPS][0:LANES-1];
   logic [1:0]              sp_ff [0:STEPS][0:LANES-1];
   logic signed [SIN_W-1:0] cx_in [1:STEPS][0:LANES-1];
   logic signed [SIN_W-1:0] cy_in [1:STEPS][0:LANES-1];
   logic signed [SIN_W-1:0] cz_in [1:STEPS][0:LANES-1];

   logic signed [SIN_W-1:0] cz0_in [0:LANES-1];
   logic [1:0]              sp0_in [0:LANES-1];
   logic [PHASE_W-1:0]      lane_ph [0:LANES-1];
   logic [PHASE_W-1:0]      ph_in [0:1];
   logic signed [SIN_W-1:0] sc_ff [0:LANES-1];
   logic signed [SIN_W-1:0] sc_in [0:LANES-1];

   logic                 rsp_valid_ff;
   logic [COORD_W-1:0]   x0_ff, y0_ff, x1_ff, y1_ff, x2_ff, y2_ff;
   logic [COORD_W-1:0]   x0_in, y0_in, x1_in, y1_in, x2_in, y2_in;
   logic [COLOR_W-1:0]   color_ff, color_in;
   logic                 vres_ff, vres_in;

   assign en     = !(rsp_valid_ff && rsp_stall);
   assign in_pop = en && in_avail;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_avail;
         for (int k = 1; k < NST; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_valid_ff <= vld_ff[NST-1];
      end
   end

   // phase of the two ring points
   always_comb begin
      logic [NUM_W-1:0]   num;
      logic [NUM_W-1:0]   r;
      logic [PHASE_W-1:0] q;
      logic [PHASE_W:0]   qr;
      for (int l = 0; l < 2; l++) begin
         num = {(l == 0) ? meta_ff[2].m0 : meta_ff[2].m1, PHASE_W'(0)};
         r   = num - qn_ff[l];
         q   = (r >= NUM_W'(geom.n)) ? q0_ff[l] + 1'b1 : q0_ff[l];
         qr  = {1'b0, q} + (PHASE_W + 1)'(1 << (SH - 1));
         ph_in[l] = {qr[SH +: SINE_TABLE_BITS], SH'(0)};
      end
   end

   // cordic setup: lanes are sin0, cos0, sin1, cos1
   always_comb begin
      logic signed [SIN_W-1:0] z;
      lane_ph[0] = ph_ff[0];
      lane_ph[1] = ph_ff[0] + PHASE_W'(QUARTER);
      lane_ph[2] = ph_ff[1];
      lane_ph[3] = ph_ff[1] + PHASE_W'(QUARTER);
      for (int l = 0; l < LANES; l++) begin
         z = SIN_W'($signed(lane_ph[l]));
         if (z > SIN_W'(QUARTER)) begin
            z = SIN_W'(HALF_TURN) - z;
         end
         if (z < -SIN_W'(QUARTER)) begin
            z = -SIN_W'(HALF_TURN) - z;
         end
         cz0_in[l] = z;
         if (lane_ph[l][13:0] != '0) begin
            sp0_in[l] = SP_NONE;
         end else if (lane_ph[l] == PHASE_W'(QUARTER)) begin
            sp0_in[l] = SP_POS;
         end else if (lane_ph[l] == PHASE_W'(3 * QUARTER)) begin
            sp0_in[l] = SP_NEG;
         end else begin
            sp0_in[l] = SP_ZERO;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < STEPS; k++) begin
         for (int l = 0; l < LANES; l++) begin
            if (!cz_ff[k][l][SIN_W-1]) begin
               cx_in[k+1][l] = cx_ff[k][l] - (cy_ff[k][l] >>> k);
               cy_in[k+1][l] = cy_ff[k][l] + (cx_ff[k][l] >>> k);
               cz_in[k+1][l] = cz_ff[k][l] - $signed(ATAN[k]);
            end else begin
               cx_in[k+1][l] = cx_ff[k][l] + (cy_ff[k][l] >>> k);
               cy_in[k+1][l] = cy_ff[k][l] - (cx_ff[k][l] >>> k);
               cz_in[k+1][l] = cz_ff[k][l] + $signed(ATAN[k]);
            end
         end
      end
   end

   always_comb begin
      logic signed [SIN_W-1:0] y;
      for (int l = 0; l < LANES; l++) begin
         y = cy_ff[STEPS][l];
         if (y > SIN_W'(SIN_ONE)) begin
            y = SIN_W'(SIN_ONE);
         end
         if (y < -SIN_W'(SIN_ONE)) begin
            y = -SIN_W'(SIN_ONE);
         end
         case (sp_ff[STEPS][l])
            SP_NONE: sc_in[l] = y;
            SP_POS:  sc_in[l] = SIN_W'(SIN_ONE);
            SP_NEG:  sc_in[l] = -SIN_W'(SIN_ONE);
            default: sc_in[l] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0] <= in_item;
         for (int k = 1; k < NST; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
         prod_ff[0] <= meta_ff[0].m0 * geom.recip;
         prod_ff[1] <= meta_ff[0].m1 * geom.recip;
         for (int l = 0; l < 2; l++) begin
            q0_ff[l] <= prod_ff[l][PHASE_W +: PHASE_W];
            qn_ff[l] <= prod_ff[l][PHASE_W +: PHASE_W] * geom.n;
            ph_ff[l] <= ph_in[l];
         end
         for (int l = 0; l < LANES; l++) begin
            cx_ff[0][l] <= SIN_W'(CORDIC_X0);
            cy_ff[0][l] <= '0;
            cz_ff[0][l] <= cz0_in[l];
            sp_ff[0][l] <= sp0_in[l];
            for (int k = 1; k <= STEPS; k++) begin
               cx_ff[k][l] <= cx_in[k][l];
               cy_ff[k][l] <= cy_in[k][l];
               cz_ff[k][l] <= cz_in[k][l];
               sp_ff[k][l] <= sp_ff[k-1][l];
            end
            sc_ff[l] <= sc_in[l];
         end
         x0_ff    <= x0_in;
         y0_ff    <= y0_in;
         x1_ff    <= x1_in;
         y1_ff    <= y1_in;
         x2_ff    <= x2_in;
         y2_ff    <= y2_in;
         color_ff <= color_in;
         vres_ff  <= vres_in;
      end
   end

   // vertex assembly
   always_comb begin
      item_type                 m;
      logic signed [HALF_W-1:0] hx1, hy1;
      logic signed [SIN_W-1:0]  s2, c2;
      m   = meta_ff[NST-1];
      hx1 = (m.role == ROLE_OUT_B) ? geom.ox : geom.ix;
      hy1 = (m.role == ROLE_OUT_B) ? geom.oy : geom.iy;
      s2  = (m.role == ROLE_OUT_B) ? sc_ff[0] : sc_ff[2];
      c2  = (m.role == ROLE_OUT_B) ? sc_ff[1] : sc_ff[3];
      if (!m.valid_res) begin
         {x0_in, y0_in, x1_in, y1_in, x2_in, y2_in} = '0;
         color_in = '0;
      end else if (m.kind == KIND_RECT) begin
         x0_in = rect_coord(m.code0[2] ? geom.ox : geom.ix, m.code0[0]);
         y0_in = rect_coord(m.code0[2] ? geom.oy : geom.iy, m.code0[1]);
         x1_in = rect_coord(m.code1[2] ? geom.ox : geom.ix, m.code1[0]);
         y1_in = rect_coord(m.code1[2] ? geom.oy : geom.iy, m.code1[1]);
         x2_in = rect_coord(m.code2[2] ? geom.ox : geom.ix, m.code2[0]);
         y2_in = rect_coord(m.code2[2] ? geom.oy : geom.iy, m.code2[1]);
         color_in = m.color;
      end else begin
         x0_in = mul_round(geom.ix, sc_ff[0]);
         y0_in = mul_round(geom.iy, sc_ff[1]);
         x1_in = mul_round(hx1, sc_ff[2]);
         y1_in = mul_round(hy1, sc_ff[3]);
         if (m.role == ROLE_FILL) begin
            x2_in = '0;
            y2_in = '0;
         end else begin
            x2_in = mul_round(geom.ox, s2);
            y2_in = mul_round(geom.oy, c2);
         end
         color_in = m.color;
      end
      vres_in = m.valid_res;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_x0           = x0_ff;
   assign rsp_y0           = y0_ff;
   assign rsp_x1           = x1_ff;
   assign rsp_y1           = y1_ff;
   assign rsp_x2           = x2_ff;
   assign rsp_y2           = y2_ff;
   assign rsp_vertex_color = color_ff;
   assign rsp_valid_res    = vres_ff;
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for the shape triangle tessellator: directed and random triangles
module tb_top;
   import stt_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [TRI_W-1:0]   req_triangle_index;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [COORD_W-1:0] rsp_x0, rsp_y0, rsp_x1, rsp_y1, rsp_x2, rsp_y2;
   logic [COLOR_W-1:0] rsp_vertex_color;
   logic               rsp_valid_res;
   logic               csr_valid;
   logic               csr_ready;
   logic [CSR_IW-1:0]  csr_index;
   logic [CSR_DW-1:0]  csr_data;

   typedef struct {
      logic [COORD_W-1:0] crd [6];
      logic [COLOR_W-1:0] color;
      logic               ok;
   } tri_type;

   localparam int ATAN_TBL [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                    41, 20, 10, 5, 3, 1, 1, 0};

   logic [TRI_W-1:0] pending_tris [$];
   tri_type          expected_tris [$];
   int               send_idle_pct;
   int               stall_pct;
   int               hold_off;
   logic             req_took;
   int               errors;

   // shadow registers
   logic        sh_kind;
   int unsigned sh_size_x, sh_size_y, sh_segs, sh_fill, sh_outline;
   int          sh_width;

   shape_triangle_tessellator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_triangle_index(req_triangle_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_x0(rsp_x0), .rsp_y0(rsp_y0), .rsp_x1(rsp_x1), .rsp_y1(rsp_y1),
      .rsp_x2(rsp_x2), .rsp_y2(rsp_y2),
      .rsp_vertex_color(rsp_vertex_color), .rsp_valid_res(rsp_valid_res),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic void add_tri(logic [TRI_W-1:0] t);
      pending_tris.insert(pending_tris.size(), t);
   endfunction

   function automatic longint clamp_coord(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   function automatic longint cordic_sine(int unsigned p);
      longint x, y, z, nx;
      x = CORDIC_X0;
      y = 0;
      p = p & 16'hFFFF;
      if ((p & 16'h3FFF) == 0) begin
         if (p == 16'h4000) return SIN_ONE;
         if (p == 16'hC000) return -SIN_ONE;
         return 0;
      end
      z = (p < 16'h8000) ? longint'(p) : longint'(p) - 65536;
      if (z > 16384) z = 32768 - z;
      if (z < -16384) z = -32768 - z;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - ATAN_TBL[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + ATAN_TBL[i];
         end
         x = nx;
      end
      if (y > SIN_ONE) y = SIN_ONE;
      if (y < -SIN_ONE) y = -SIN_ONE;
      return y;
   endfunction

   function automatic void ring_vertex(longint hx, longint hy, int unsigned j,
                                       int unsigned n, output logic [23:0] vx,
                                       output logic [23:0] vy);
      int unsigned ph, addr;
      longint s, c;
      ph   = ((j % n) << 16) / n;
      addr = ((ph + 32) >> 6) & 10'h3FF;
      ph   = addr << 6;
      s    = cordic_sine(ph);
      c    = cordic_sine(ph + 16'h4000);
      vx   = 24'(clamp_coord((hx * s + 16384) >>> 15));
      vy   = 24'(clamp_coord((hy * c + 16384) >>> 15));
   endfunction

   function automatic tri_type tessellate(logic [TRI_W-1:0] t);
      tri_type r;
      longint ix, iy, ox, oy, aw, vx, vy;
      int unsigned n, total, s;
      logic [2:0] code;
      foreach (r.crd[i]) r.crd[i] = '0;
      r.color = '0;
      r.ok    = 1'b0;
      ix = longint'((sh_size_x + 1) >> 1) + (sh_width < 0 ? sh_width : 0);
      iy = longint'((sh_size_y + 1) >> 1) + (sh_width < 0 ? sh_width : 0);
      aw = sh_width < 0 ? -sh_width : sh_width;
      ox = ix + aw;
      oy = iy + aw;
      if (sh_kind == KIND_RECT) begin
         total = (sh_width != 0) ? RECT_TOTAL : RECT_FILL;
         if (t >= total) return r;
         for (int k = 0; k < 3; k++) begin
            code = RECT_TRIS[t][k];
            vx = code[2] ? ox : ix;
            vy = code[2] ? oy : iy;
            if (code[0]) vx = -vx;
            if (code[1]) vy = -vy;
            r.crd[2*k]   = 24'(clamp_coord(vx));
            r.crd[2*k+1] = 24'(clamp_coord(vy));
         end
         r.color = (t < RECT_FILL) ? sh_fill : sh_outline;
      end else begin
         n = sh_segs;
         if (n < 3) n = 3;
         if (n > 1024) n = 1024;
         total = (sh_width != 0) ? 3 * n : n;
         if (t >= total) return r;
         if (t < n) begin
            ring_vertex(ix, iy, t, n, r.crd[0], r.crd[1]);
            ring_vertex(ix, iy, t + 1, n, r.crd[2], r.crd[3]);
            r.color = sh_fill;
         end else begin
            s = (t - n) >> 1;
            ring_vertex(ix, iy, s, n, r.crd[0], r.crd[1]);
            if (((t - n) & 1) == 0) begin
               ring_vertex(ix, iy, s + 1, n, r.crd[2], r.crd[3]);
               ring_vertex(ox, oy, s + 1, n, r.crd[4], r.crd[5]);
            end else begin
               ring_vertex(ox, oy, s + 1, n, r.crd[2], r.crd[3]);
               ring_vertex(ox, oy, s, n, r.crd[4], r.crd[5]);
            end
            r.color = sh_outline;
         end
      end
      r.ok = 1'b1;
      return r;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_tris.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid          <= 1'b1;
            req_triangle_index <= pending_tris.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off  <= hold_off - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      tri_type exp_t;
      logic [COORD_W-1:0] got [6];
      req_took <= req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_x0, rsp_y0, rsp_x1, rsp_y1, rsp_x2, rsp_y2};
         if (expected_tris.size() == 0) begin
            $display("%0t unexpected transfer on result channel", $realtime);
            errors++;
         end else begin
            exp_t = expected_tris.pop_front();
            for (int i = 0; i < 6; i++) begin
               if (got[i] !== exp_t.crd[i]) begin
                  $display("%0t coord %0d exp %h got %h", $realtime, i, exp_t.crd[i], got[i]);
                  errors++;
               end
            end
            if (rsp_vertex_color !== exp_t.color) begin
               $display("%0t color exp %h got %h", $realtime, exp_t.color, rsp_vertex_color);
               errors++;
            end
            if (rsp_valid_res !== exp_t.ok) begin
               $display("%0t valid_res exp %b got %b", $realtime, exp_t.ok, rsp_valid_res);
               errors++;
            end
         end
      end
      if (!reset && req_valid && !req_stall)
         expected_tris.insert(expected_tris.size(), tessellate(req_triangle_index));
   end

   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SHAPE_KIND:    sh_kind    = val[0];
         REG_SIZE_X:        sh_size_x  = val[21:0];
         REG_SIZE_Y:        sh_size_y  = val[21:0];
         REG_OUTLINE_WIDTH: sh_width   = int'(signed'(val[20:0]));
         REG_SEGMENT_COUNT: sh_segs    = val[10:0];
         REG_FILL_COLOR:    sh_fill    = val;
         REG_OUTLINE_COLOR: sh_outline = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      do @(posedge clock);
      while (pending_tris.size() > 0 || req_valid || expected_tris.size() > 0 || hold_off > 0);
      repeat (30) @(posedge clock);
   endtask

   function automatic int unsigned tri_count();
      int unsigned n;
      n = (sh_segs < 3) ? 3 : (sh_segs > 1024 ? 1024 : sh_segs);
      if (sh_kind == KIND_RECT) return (sh_width != 0) ? RECT_TOTAL : RECT_FILL;
      return (sh_width != 0) ? 3 * n : n;
   endfunction

   task automatic queue_random(int count);
      int unsigned total, pick;
      total = tri_count();
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 75)
            add_tri(TRI_W'($urandom_range(total - 1)));
         else if (pick < 88)
            add_tri(TRI_W'(total - 2 + $urandom_range(4)));
         else
            add_tri(TRI_W'($urandom));
      end
   endtask

   initial begin
      int unsigned sx, sy, segs;
      int w;
      int ell_tris [10] = '{0, 1, 31, 32, 33, 94, 95, 96, 2730, 4095};
      reset = 1'b1;
      req_valid = 1'b0;
      req_triangle_index = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_took = 1'b0;
      hold_off = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      errors = 0;
      sh_kind = KIND_RECT;
      sh_size_x = 2560;
      sh_size_y = 2560;
      sh_width = 256;
      sh_segs = 32;
      sh_fill = 32'hFFFF_FFFF;
      sh_outline = 32'h0000_00FF;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // rectangle with reset settings, every triangle and past the end
      for (int i = 0; i < 12; i++) add_tri(TRI_W'(i));
      add_tri(TRI_W'(4095));
      drain();

      // ellipse, fill and outline boundaries, wrap, past the end
      write_reg(REG_SHAPE_KIND, KIND_ELLIPSE);
      write_reg(REG_FILL_COLOR, 32'h1234_5678);
      write_reg(REG_OUTLINE_COLOR, 32'hA5C3_0F96);
      foreach (ell_tris[i]) add_tri(TRI_W'(ell_tris[i]));
      drain();

      // zero width, negative width, extremes of size and segment count
      write_reg(REG_OUTLINE_WIDTH, 32'h0);
      write_reg(REG_SEGMENT_COUNT, 32'd1024);
      write_reg(REG_SIZE_X, 32'h3F_FFFF);
      write_reg(REG_SIZE_Y, 32'h0);
      add_tri(TRI_W'(0));
      add_tri(TRI_W'(1023));
      add_tri(TRI_W'(1024));
      drain();
      write_reg(REG_OUTLINE_WIDTH, 32'h10_0000);
      write_reg(REG_SEGMENT_COUNT, 32'd0);
      add_tri(TRI_W'(2));
      add_tri(TRI_W'(5));
      add_tri(TRI_W'(8));
      add_tri(TRI_W'(9));
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         case ($urandom_range(5))
            0: sx = 0;
            1: sx = 22'h3F_FFFF;
            2: sx = $urandom_range(22'h3F_FFFF);
            default: sx = $urandom_range(8192);
         endcase
         case ($urandom_range(5))
            0: sy = 0;
            1: sy = 22'h3F_FFFF;
            2: sy = $urandom_range(22'h3F_FFFF);
            default: sy = $urandom_range(8192);
         endcase
         case ($urandom_range(6))
            0: w = 0;
            1: w = -1048576;
            2: w = 1048575;
            3: w = int'($urandom_range(2097151)) - 1048576;
            default: w = int'($urandom_range(2048)) - 1024;
         endcase
         case ($urandom_range(5))
            0: segs = $urandom_range(2);
            1: segs = 1024 + $urandom_range(1023);
            2: segs = 3;
            default: segs = $urandom_range(200, 3);
         endcase
         write_reg(REG_SHAPE_KIND, (ph % 3 == 0) ? KIND_RECT : KIND_ELLIPSE);
         write_reg(REG_SIZE_X, sx);
         write_reg(REG_SIZE_Y, sy);
         write_reg(REG_OUTLINE_WIDTH, 32'(w) & 32'h1F_FFFF);
         write_reg(REG_SEGMENT_COUNT, segs);
         write_reg(REG_FILL_COLOR, $urandom);
         write_reg(REG_OUTLINE_COLOR, $urandom);
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 61; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 61; end
            default: begin send_idle_pct = 37; stall_pct = 37; end
         endcase
         if (ph == 4) hold_off = 300;
         queue_random(80);
         drain();
      end

      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
